### rtl/core/gsr_pkg.sv
`default_nettype none

package gsr_pkg;

  // Geometry of the label and the glyph.
  localparam int MAX_COLUMNS  = 32;
  localparam int GLYPH_ROWS   = 16;

  // Fixed field widths.
  localparam int ROW_PIX      = 16;
  localparam int PIX_PER_WORD = 8;
  localparam int NIB_W        = 4;
  localparam int ROW_W        = 4;
  localparam int COL_W        = 6;
  localparam int OFF_W        = 10;
  localparam int WORD_W       = 32;
  localparam int LIMIT_W      = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int CNT_W        = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR     = 2'd0,
    REG_SHADOW_COLOR = 2'd1,
    REG_LABEL_LENGTH = 2'd2
  } gsr_cfg_reg_t;

  // One result word as it waits in the output buffer.
  typedef struct packed {
    logic [OFF_W-1:0]  word_offset;
    logic [WORD_W-1:0] pixel_word;
    logic [COL_W-1:0]  columns_used;
    logic              last;
  } gsr_word_t;

  // Status of the output buffer as seen by the row control.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             take_ok;
  } gsr_q_stat_t;

endpackage

`default_nettype wire

### rtl/core/gsr_lane.sv
`default_nettype none

module gsr_lane (
  input  logic                      pix_bit,
  input  logic                      shade_bit,
  input  logic [gsr_pkg::NIB_W-1:0] fg_color,
  input  logic [gsr_pkg::NIB_W-1:0] shadow_color,
  output logic [gsr_pkg::NIB_W-1:0] nibble
);
  import gsr_pkg::*;

  // A set pixel wins over its shadow; everything else is background.
  always_comb begin
    if (pix_bit) begin
      nibble = fg_color;
    end else if (shade_bit) begin
      nibble = shadow_color;
    end else begin
      nibble = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/gsr_out_queue.sv
`default_nettype none

module gsr_out_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [gsr_pkg::CNT_W-1:0] push_n,
  input  gsr_pkg::gsr_word_t        push_w0,
  input  gsr_pkg::gsr_word_t        push_w1,
  input  logic                      pop_ready,
  output logic                      head_valid,
  output gsr_pkg::gsr_word_t        head,
  output gsr_pkg::gsr_q_stat_t      stat
);
  import gsr_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  gsr_word_t        head_r, head_nxt;
  gsr_word_t        tail_r, tail_nxt;
  logic             pop;

  assign head_valid   = (count_r != '0);
  assign head         = head_r;
  assign pop          = head_valid && pop_ready;
  assign stat.count   = count_r;
  // A new row is taken only when the buffer is empty by the end of this cycle.
  assign stat.take_ok = (count_r == '0) || ((count_r == CNT_W'(1)) && pop_ready);

  // A push always lands in an emptied buffer, so it simply overwrites both slots.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (push) begin
      count_nxt = push_n;
      head_nxt  = push_w0;
      tail_nxt  = push_w1;
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/glyph_row_shadow_rasterizer.sv
`default_nettype none

// Glyph row shadow rasterizer. Each accepted row of a 1-bit glyph comes out as
// one 32-bit word of eight 4-bit pixels for a narrow glyph, or two words (left
// half first) for a wide one, with the word offset in the tile area and the
// label column in use. The first word is offered the cycle after the row is
// accepted. Sixteen pixel lanes shade the whole row at once, and a two-word
// output buffer feeds the output port one word per cycle while out_ready is
// high, so that port is what sets the rate. Rows that produce nothing
// (stopped label, glyph that does not fit) push no words.
// Configuration writes are taken at once and must only be made while idle.
module glyph_row_shadow_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gsr_pkg::ROW_PIX-1:0]    in_row_bits,
  input  logic                           in_wide,
  input  logic [gsr_pkg::ROW_W-1:0]      in_row,
  input  logic                           in_new_label,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gsr_pkg::OFF_W-1:0]      out_word_offset,
  output logic [gsr_pkg::WORD_W-1:0]     out_pixel_word,
  output logic [gsr_pkg::COL_W-1:0]      out_columns_used,
  output logic                           out_last
);
  import gsr_pkg::*;

  localparam logic [ROW_W:0]   ROWS_V     = (ROW_W+1)'(GLYPH_ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW_V = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [LIMIT_W-1:0] MAX_COL_V = LIMIT_W'(MAX_COLUMNS);

  // Configuration and row state.
  logic [NIB_W-1:0]   fg_r;
  logic [NIB_W-1:0]   sh_r;
  logic [COL_W-1:0]   label_len_r;
  logic [ROW_PIX-1:0] prev_r, prev_nxt;
  logic [COL_W-1:0]   column_r, column_nxt;
  logic               stopped_r, stopped_nxt;

  logic               in_accept;
  logic [COL_W-1:0]   col_eff;
  logic               stop_eff;
  logic               row_ok;
  logic               row_zero;
  logic [LIMIT_W-1:0] limit;
  logic               fits;
  logic               active;
  logic               emit;
  logic [ROW_PIX-1:0] bits_m;
  logic [ROW_PIX-1:0] prev_use;
  logic [ROW_PIX-1:0] shade;
  logic [LIMIT_W-1:0] col_sum;
  logic [OFF_W-1:0]   base_off;
  logic [CNT_W-1:0]   push_n;
  logic [NIB_W-1:0]   nib [ROW_PIX];
  logic [WORD_W-1:0]  pix_lo;
  logic [WORD_W-1:0]  pix_hi;
  gsr_word_t          w0, w1, head;
  gsr_q_stat_t        q_stat;

  assign in_ready  = q_stat.take_ok;
  assign in_accept = in_valid && in_ready;

  // A new label clears column and stop before the row is looked at.
  always_comb begin
    col_eff  = in_new_label ? '0 : column_r;
    stop_eff = in_new_label ? 1'b0 : stopped_r;
    row_ok   = ({1'b0, in_row} < ROWS_V);
    row_zero = (in_row == '0);
    limit    = ((LIMIT_W'(label_len_r) > MAX_COL_V) ? MAX_COL_V : LIMIT_W'(label_len_r));
    fits     = ((LIMIT_W'(col_eff) + LIMIT_W'(in_wide)) < limit);
    active   = !stop_eff && row_ok;
    emit     = active && (!row_zero || fits);
    bits_m   = in_wide ? in_row_bits
                       : {(ROW_PIX-PIX_PER_WORD)'(0), in_row_bits[PIX_PER_WORD-1:0]};
    prev_use = row_zero ? '0 : prev_r;
    shade    = ((bits_m | prev_use) << 1) | prev_use;
    push_n   = emit ? (in_wide ? CNT_W'(2) : CNT_W'(1)) : '0;
    col_sum  = LIMIT_W'(col_eff) + LIMIT_W'(1) + LIMIT_W'(in_wide);
  end

  // One lane per pixel of the row.
  for (genvar i = 0; i < ROW_PIX; i++) begin : g_lane
    gsr_lane u_lane (
      .pix_bit      (bits_m[i]),
      .shade_bit    (shade[i]),
      .fg_color     (fg_r),
      .shadow_color (sh_r),
      .nibble       (nib[i])
    );
  end

  // Merge the lanes into the left and right words.
  for (genvar j = 0; j < PIX_PER_WORD; j++) begin : g_merge
    assign pix_lo[j*NIB_W +: NIB_W] = nib[j];
    assign pix_hi[j*NIB_W +: NIB_W] = nib[j+PIX_PER_WORD];
  end

  // Offset: column*8 + half*8 + upper tile row*256 + row within the tile.
  always_comb begin
    base_off = OFF_W'({col_eff, 3'b000}) + OFF_W'({in_row[ROW_W-1], 8'b0000_0000})
             + OFF_W'(in_row[ROW_W-2:0]);
    w0.word_offset  = base_off;
    w0.pixel_word   = pix_lo;
    w0.columns_used = col_eff;
    w0.last         = !in_wide;
    w1.word_offset  = base_off + OFF_W'(PIX_PER_WORD);
    w1.pixel_word   = pix_hi;
    w1.columns_used = col_eff;
    w1.last         = 1'b1;
  end

  // Row state after this row: stop on a misfit, advance the column after the last row.
  always_comb begin
    column_nxt  = col_eff;
    stopped_nxt = stop_eff;
    prev_nxt    = prev_r;
    if (active) begin
      if (row_zero) begin
        prev_nxt = '0;
      end
      if (row_zero && !fits) begin
        stopped_nxt = 1'b1;
      end else begin
        prev_nxt = bits_m;
        if (in_row == LAST_ROW_V) begin
          column_nxt = col_sum[LIMIT_W-1] ? '1 : col_sum[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= NIB_W'(1);
      sh_r        <= NIB_W'(2);
      label_len_r <= COL_W'(32);
      prev_r      <= '0;
      column_r    <= '0;
      stopped_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FG_COLOR:     fg_r        <= cfg_data[NIB_W-1:0];
          REG_SHADOW_COLOR: sh_r        <= cfg_data[NIB_W-1:0];
          REG_LABEL_LENGTH: label_len_r <= cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        prev_r    <= prev_nxt;
        column_r  <= column_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  gsr_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_n     (push_n),
    .push_w0    (w0),
    .push_w1    (w1),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .stat       (q_stat)
  );

  assign out_word_offset  = head.word_offset;
  assign out_pixel_word   = head.pixel_word;
  assign out_columns_used = head.columns_used;
  assign out_last         = head.last;

  // The buffer never holds more than the two words of one row.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count != CNT_W'(3))
    else $error("output buffer count out of range");

  // A word that is not the last of its row always has its partner queued behind it.
  a_head_partner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> q_stat.count == CNT_W'(2))
    else $error("left half offered without right half queued");

  // A wide row that produces words offers its left half next.
  a_wide_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && push_n == CNT_W'(2) |=> out_valid && !out_last)
    else $error("wide row did not offer its left half first");

  // Column and stop state move only when a row is taken.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(column_r) && $stable(stopped_r))
    else $error("label state changed without an accepted row");

endmodule

`default_nettype wire
